FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the given reset is high.
`define ASSERT_CLKRST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/plc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_pkg: shared types and codes of the positional list store
// Request and status codes, and the command that the controller sends to
// every cell of the list.
// ----------------------------------------------------------------------------
package plc_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_GET    = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_END  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam int unsigned POS_W   = 9;
  localparam int unsigned SIZE_W  = 5;
  localparam int unsigned REF_W   = 32;
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned CNT_W   = 8;

  // Broadcast to all cells: insert opens a slot, delete closes one.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

FILE: sv/plc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_cell: one slot of the positional list
// Holds one entry and, on an insert or delete, takes the entry of its left or
// right neighbour, or the new entry, by comparing its own index with the
// broadcast position.
// ----------------------------------------------------------------------------
module plc_cell #(
  parameter int unsigned PW          = 4,
  parameter int unsigned COUNT_WIDTH = 8,
  parameter int unsigned INDEX       = 0
) (
  input  logic                    clk,
  input  plc_pkg::cell_cmd_t      cmd,
  input  logic [PW-1:0]           pos,
  input  logic [31:0]             new_ref,
  input  logic [COUNT_WIDTH-1:0]  new_count,
  input  logic [31:0]             new_price,
  input  logic [31:0]             left_ref,
  input  logic [COUNT_WIDTH-1:0]  left_count,
  input  logic [31:0]             left_price,
  input  logic [31:0]             right_ref,
  input  logic [COUNT_WIDTH-1:0]  right_count,
  input  logic [31:0]             right_price,
  output logic [31:0]             entry_ref,
  output logic [COUNT_WIDTH-1:0]  entry_count,
  output logic [31:0]             entry_price,
  output logic [31:0]             rd_ref,
  output logic [COUNT_WIDTH-1:0]  rd_count,
  output logic [31:0]             rd_price
);
  import plc_pkg::*;

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic at_pos;
  logic past_pos;

  assign at_pos   = (pos == IDX);
  assign past_pos = (IDX > pos);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (at_pos) begin
        entry_ref   <= new_ref;
        entry_count <= new_count;
        entry_price <= new_price;
      end else if (past_pos) begin
        entry_ref   <= left_ref;
        entry_count <= left_count;
        entry_price <= left_price;
      end
    end else if (cmd.del && (at_pos || past_pos)) begin
      entry_ref   <= right_ref;
      entry_count <= right_count;
      entry_price <= right_price;
    end
  end

  // Only the addressed cell drives the shared read bus.
  assign rd_ref   = at_pos ? entry_ref : '0;
  assign rd_count = at_pos ? entry_count : '0;
  assign rd_price = at_pos ? entry_price : '0;

endmodule

FILE: sv/plc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_ctrl: request decode and result register of the positional list
// Keeps the entry count, works out the position and status of each request,
// commands the cells and registers the result.
// ----------------------------------------------------------------------------
module plc_ctrl #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned COUNT_WIDTH = 8,
  parameter int unsigned PW          = 4,
  parameter int unsigned TW          = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    req_type,
  input  logic signed [plc_pkg::POS_W-1:0] position,
  output plc_pkg::cell_cmd_t            cmd,
  output logic [PW-1:0]                 pos,
  input  logic [31:0]                   rd_ref,
  input  logic [COUNT_WIDTH-1:0]        rd_count,
  input  logic [31:0]                   rd_price,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [plc_pkg::SIZE_W-1:0]    used_position,
  output logic [31:0]                   out_item_ref,
  output logic [plc_pkg::CNT_W-1:0]     out_item_count,
  output logic [31:0]                   out_price_bits,
  output logic [plc_pkg::SIZE_W-1:0]    list_size,
  output logic                          list_empty
);
  import plc_pkg::*;

  logic [TW-1:0]    total;
  logic [TW-1:0]    total_next;
  req_t             req;
  logic [POS_W-1:0] p_req;
  logic [POS_W-1:0] p_add;
  logic [POS_W-1:0] tot_ext;
  logic             full;
  logic             miss;
  logic             hit_get;
  status_t          st;

  always_comb begin
    req     = req_t'(req_type);
    // A negative position selects the first entry.
    p_req   = position[POS_W-1] ? '0 : {1'b0, position[POS_W-2:0]};
    tot_ext = POS_W'(total);
    full    = (total == TW'(DEPTH));
    p_add   = (p_req > tot_ext) ? tot_ext : p_req;
    miss    = (total == '0) || (p_req >= tot_ext);
    hit_get = 1'b0;
    cmd.ins = 1'b0;
    cmd.del = 1'b0;
    pos     = PW'(p_req);
    total_next = total;
    st      = ST_OK;
    unique case (req)
      REQ_ADD: begin
        pos = PW'(p_add);
        if (full) begin
          st = ST_FULL;
        end else begin
          cmd.ins    = start;
          total_next = total + TW'(1);
        end
      end
      REQ_REMOVE: begin
        if (miss) begin
          st = ST_END;
        end else begin
          cmd.del    = start;
          total_next = total - TW'(1);
        end
      end
      REQ_GET: begin
        if (miss) begin
          st = ST_END;
        end else begin
          hit_get = 1'b1;
        end
      end
      REQ_CLEAR: begin
        total_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      total <= '0;
    end else begin
      done <= start;
      if (start) begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      status         <= st;
      used_position  <= (req == REQ_ADD && !full) ? SIZE_W'(p_add) : '0;
      out_item_ref   <= hit_get ? rd_ref : '0;
      out_item_count <= hit_get ? CNT_W'(rd_count) : '0;
      out_price_bits <= hit_get ? rd_price : '0;
      list_size      <= SIZE_W'(total_next);
      list_empty     <= (total_next == '0);
    end
  end

endmodule

FILE: sv/positional_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store: ordered list with insert and remove by position
// A row of DEPTH cells, one entry each, that shift right on an add and left
// on a remove, under a controller that keeps the entry count.
// ----------------------------------------------------------------------------
//
//  channel   handshake      payload
//  request   start / busy   req_type, position, item_ref, item_count, price_bits
//  result    done           status, used_position, out_item_ref, out_item_count,
//                           out_price_bits, list_size, list_empty
//
// One request per clock cycle; its result appears on the cycle after it is
// taken. Every cell compares its own index with the position and moves its
// entry at the clock edge that takes the request, so busy never rises.
// Reset (rst, synchronous) empties the list and clears the result strobe; the
// entry contents are not cleared and are only read once written.
// The receiver takes every result as it comes; nothing waits on it.
// ----------------------------------------------------------------------------
module positional_list_store #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        req_type,
  input  logic signed [plc_pkg::POS_W-1:0]  position,
  input  logic [31:0]                       item_ref,
  input  logic [plc_pkg::CNT_W-1:0]         item_count,
  input  logic [31:0]                       price_bits,
  output logic                              done,
  output logic [1:0]                        status,
  output logic [plc_pkg::SIZE_W-1:0]        used_position,
  output logic [31:0]                       out_item_ref,
  output logic [plc_pkg::CNT_W-1:0]         out_item_count,
  output logic [31:0]                       out_price_bits,
  output logic [plc_pkg::SIZE_W-1:0]        list_size,
  output logic                              list_empty
);
  import plc_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned TW = $clog2(DEPTH + 1);

  cell_cmd_t              cmd;
  logic [PW-1:0]          pos;
  logic [COUNT_WIDTH-1:0] new_count;
  logic [31:0]            e_ref   [DEPTH];
  logic [COUNT_WIDTH-1:0] e_count [DEPTH];
  logic [31:0]            e_price [DEPTH];
  logic [31:0]            c_ref   [DEPTH];
  logic [COUNT_WIDTH-1:0] c_count [DEPTH];
  logic [31:0]            c_price [DEPTH];
  logic [31:0]            rd_ref;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [31:0]            rd_price;

  assign busy      = 1'b0;
  assign new_count = COUNT_WIDTH'(item_count);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0]            l_ref;
    logic [COUNT_WIDTH-1:0] l_count;
    logic [31:0]            l_price;
    logic [31:0]            r_ref;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [31:0]            r_price;

    if (i == 0) begin : g_first
      assign l_ref   = item_ref;
      assign l_count = new_count;
      assign l_price = price_bits;
    end else begin : g_mid
      assign l_ref   = e_ref[i-1];
      assign l_count = e_count[i-1];
      assign l_price = e_price[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_ref   = e_ref[i];
      assign r_count = e_count[i];
      assign r_price = e_price[i];
    end else begin : g_inner
      assign r_ref   = e_ref[i+1];
      assign r_count = e_count[i+1];
      assign r_price = e_price[i+1];
    end

    plc_cell #(
      .PW          (PW),
      .COUNT_WIDTH (COUNT_WIDTH),
      .INDEX       (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (pos),
      .new_ref     (item_ref),
      .new_count   (new_count),
      .new_price   (price_bits),
      .left_ref    (l_ref),
      .left_count  (l_count),
      .left_price  (l_price),
      .right_ref   (r_ref),
      .right_count (r_count),
      .right_price (r_price),
      .entry_ref   (e_ref[i]),
      .entry_count (e_count[i]),
      .entry_price (e_price[i]),
      .rd_ref      (c_ref[i]),
      .rd_count    (c_count[i]),
      .rd_price    (c_price[i])
    );
  end

  // At most one cell drives a non-zero word, so an OR gathers the read.
  always_comb begin
    rd_ref   = '0;
    rd_count = '0;
    rd_price = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_ref   = rd_ref | c_ref[i];
      rd_count = rd_count | c_count[i];
      rd_price = rd_price | c_price[i];
    end
  end

  plc_ctrl #(
    .DEPTH       (DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH),
    .PW          (PW),
    .TW          (TW)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start && !busy),
    .req_type       (req_type),
    .position       (position),
    .cmd            (cmd),
    .pos            (pos),
    .rd_ref         (rd_ref),
    .rd_count       (rd_count),
    .rd_price       (rd_price),
    .done           (done),
    .status         (status),
    .used_position  (used_position),
    .out_item_ref   (out_item_ref),
    .out_item_count (out_item_count),
    .out_price_bits (out_price_bits),
    .list_size      (list_size),
    .list_empty     (list_empty)
  );

endmodule

FILE: sv/plc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plc_check: port-level checks of the positional list store
// Watches the request and result ports over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plc_check (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        req_type,
  input logic                              done,
  input logic [1:0]                        status,
  input logic [plc_pkg::SIZE_W-1:0]        used_position,
  input logic [31:0]                       out_item_ref,
  input logic [plc_pkg::CNT_W-1:0]         out_item_count,
  input logic [31:0]                       out_price_bits,
  input logic [plc_pkg::SIZE_W-1:0]        list_size,
  input logic                              list_empty
);
  import plc_pkg::*;

  // Every request taken yields exactly one result on the next cycle.
  `ASSERT_CLKRST(a_req_gives_result, clk, rst, (start && !busy) |=> done, "request lost")
  `ASSERT_CLKRST(a_no_spurious_result, clk, rst, !(start && !busy) |=> !done, "spurious result")
  // A failed request reports no position and no entry data.
  `ASSERT_CLKRST(a_fail_zero, clk, rst, (done && status != ST_OK) |-> (used_position == '0 && out_item_ref == '0 && out_item_count == '0 && out_price_bits == '0), "failed request carries data")
  // Clearing always leaves an empty list.
  `ASSERT_CLKRST(a_clear_empties, clk, rst, (start && !busy && req_type == REQ_CLEAR) |=> (list_empty && list_size == '0), "clear left entries")
  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !done, "result during reset")

endmodule

bind positional_list_store plc_check u_plc_check (.*);
